### sv/sbde_pkg.sv
// ----------------------------------------------------------------------------
// sbde_pkg: shared types and constants of the six-button debouncer
// Time width, button numbering, register indexes and the structs that pass
// configuration and per-button status between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sbde_pkg;

  // Width of stored times; the sampled millisecond counter is cut to this
  localparam int TIME_WIDTH  = 32;
  localparam int NOW_WIDTH   = 32;
  localparam int NUM_BUTTONS = 6;
  localparam int MS_WIDTH    = 16;
  localparam int CFG_IDX_W   = 2;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [MS_WIDTH-1:0]   ms_t;

  // Button positions in the level and event vectors
  localparam int BTN_NEUTRAL      = 0;
  localparam int BTN_SCREEN       = 1;
  localparam int BTN_START        = 2;
  localparam int BTN_LAUNCH       = 3;
  localparam int BTN_LEFT_PADDLE  = 4;
  localparam int BTN_RIGHT_PADDLE = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1
  } cfg_reg_t;

  localparam ms_t DEBOUNCE_RESET = 16'd50;
  localparam ms_t HOLD_RESET     = 16'd50;

  typedef struct packed {
    ms_t debounce_ms;
    ms_t hold_ms;
  } cfg_t;

  // Per-button outcome of one sample
  typedef struct packed {
    logic changed;
    logic event_bit;
  } btn_stat_t;

endpackage

`default_nettype wire

### sv/sbde_in_if.sv
// ----------------------------------------------------------------------------
// sbde_in_if: sample channel
// One word is the millisecond time plus six active-low button levels.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbde_in_if;
  import sbde_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [NOW_WIDTH-1:0] now_ms;
  logic                 neutral_level;
  logic                 screen_level;
  logic                 start_level;
  logic                 launch_level;
  logic                 left_paddle_level;
  logic                 right_paddle_level;

  modport source (
    output valid, now_ms, neutral_level, screen_level, start_level,
           launch_level, left_paddle_level, right_paddle_level,
    input  ready
  );

  modport sink (
    input  valid, now_ms, neutral_level, screen_level, start_level,
           launch_level, left_paddle_level, right_paddle_level,
    output ready
  );
endinterface

`default_nettype wire

### sv/sbde_out_if.sv
// ----------------------------------------------------------------------------
// sbde_out_if: event channel
// One word per sample on which any debounced button state changed.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbde_out_if;
  logic valid;
  logic ready;
  logic neutral_event;
  logic screen_event;
  logic start_event;
  logic launch_event;
  logic left_paddle_event;
  logic right_paddle_event;

  modport source (
    output valid, neutral_event, screen_event, start_event, launch_event,
           left_paddle_event, right_paddle_event,
    input  ready
  );

  modport sink (
    input  valid, neutral_event, screen_event, start_event, launch_event,
           left_paddle_event, right_paddle_event,
    output ready
  );
endinterface

`default_nettype wire

### sv/sbde_cfg_if.sv
// ----------------------------------------------------------------------------
// sbde_cfg_if: configuration write channel
// Carries a register index and 16-bit write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbde_cfg_if;
  import sbde_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MS_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/sbde_button.sv
// ----------------------------------------------------------------------------
// sbde_button: debounce state of one button
// Holds the pressed flag, last edge time and hold start; qualifies press and
// release edges against the debounce and hold intervals for each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module sbde_button (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic               level,
  input  wire sbde_pkg::time_t    now,
  input  wire sbde_pkg::cfg_t     cfg_q,
  output sbde_pkg::btn_stat_t     stat
);
  import sbde_pkg::*;

  logic  pressed;
  time_t last_edge;
  time_t hold_start;

  logic  low;
  time_t since_edge;
  time_t hold_base;
  time_t since_hold;
  logic  debounce_ok;
  logic  hold_ok;
  logic  press;
  logic  release_edge;
  time_t hold_start_next;

  // Qualify edges; wrapping subtraction gives elapsed time
  always_comb begin
    low          = ~level;
    since_edge   = now - last_edge;
    debounce_ok  = since_edge >= TIME_WIDTH'(cfg_q.debounce_ms);
    hold_base    = (hold_start == '0) ? now : hold_start;
    since_hold   = now - hold_base;
    hold_ok      = since_hold >= TIME_WIDTH'(cfg_q.hold_ms);
    press        = low && !pressed && debounce_ok && hold_ok;
    release_edge = !low && pressed && debounce_ok;

    hold_start_next = hold_start;
    if (!low) begin
      hold_start_next = '0;
    end else if (!pressed && debounce_ok) begin
      hold_start_next = hold_base;
    end
  end

  assign stat.changed   = press || release_edge;
  assign stat.event_bit = press;

  // Advance state when the sample retires
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed    <= 1'b0;
      last_edge  <= '0;
      hold_start <= '0;
    end else if (fire) begin
      hold_start <= hold_start_next;
      if (press || release_edge) begin
        pressed   <= press;
        last_edge <= now;
      end
    end
  end

`ifndef ASSERT_OFF
  a_edge_time: assert property (@(posedge clk) disable iff (rst)
    fire && (press || release_edge) |=> last_edge == $past(now))
    else $error("last edge time not taken on accepted edge");

  a_hold_clear: assert property (@(posedge clk) disable iff (rst)
    fire && level |=> hold_start == '0)
    else $error("hold start not cleared on high level");

  a_flag_quiet: assert property (@(posedge clk) disable iff (rst)
    !fire || !(press || release_edge) |=> $stable(pressed))
    else $error("pressed flag moved without an accepted edge");
`endif

endmodule

`default_nettype wire

### sv/six_button_debounce_event.sv
// ----------------------------------------------------------------------------
// six_button_debounce_event: six-button debouncer with hold qualification
// Input register, six per-button debounce units and an event output register.
// ----------------------------------------------------------------------------
// Takes one sample word per clock unless a changing sample waits on a full
// output register, and emits one event word for each sample on which a
// debounced button state changes; a word that changes nothing is absorbed.
// A sample is held in the input register, where all six buttons evaluate
// and update their state together when it retires, and its event word is
// then loaded into the output register. An event field is 1 for a press and
// 0 for a release or no change. Write debounce_ms (index 0) and hold_ms
// (index 1) only while no sample is in flight; other indexes are ignored.
`default_nettype none

module six_button_debounce_event (
  input wire logic  clk,
  input wire logic  rst,
  sbde_in_if.sink   sample,
  sbde_out_if.source result,
  sbde_cfg_if.sink  cfg
);
  import sbde_pkg::*;

  logic                   s1_valid;
  time_t                  s1_now;
  logic [NUM_BUTTONS-1:0] s1_level;
  cfg_t                   cfg_q;
  btn_stat_t              stat [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] changed;
  logic [NUM_BUTTONS-1:0] ev_next;
  logic                   any_change;
  logic                   out_valid;
  logic [NUM_BUTTONS-1:0] out_ev;
  logic                   out_free;
  logic                   s1_adv;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.debounce_ms <= DEBOUNCE_RESET;
      cfg_q.hold_ms     <= HOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE: cfg_q.debounce_ms <= cfg.data;
        REG_HOLD:     cfg_q.hold_ms     <= cfg.data;
        default: ;
      endcase
    end
  end

  // Retire the held sample unless its event word finds the output full
  assign out_free     = !out_valid || result.ready;
  assign s1_adv       = s1_valid && (!any_change || out_free);
  assign sample.ready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_now                     <= TIME_WIDTH'(sample.now_ms);
      s1_level[BTN_NEUTRAL]      <= sample.neutral_level;
      s1_level[BTN_SCREEN]       <= sample.screen_level;
      s1_level[BTN_START]        <= sample.start_level;
      s1_level[BTN_LAUNCH]       <= sample.launch_level;
      s1_level[BTN_LEFT_PADDLE]  <= sample.left_paddle_level;
      s1_level[BTN_RIGHT_PADDLE] <= sample.right_paddle_level;
    end
  end

  // Per-button debounce units
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    sbde_button u_btn (
      .clk   (clk),
      .rst   (rst),
      .fire  (s1_adv),
      .level (s1_level[b]),
      .now   (s1_now),
      .cfg_q (cfg_q),
      .stat  (stat[b])
    );
  end

  // Gather changes and event bits
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      changed[b] = stat[b].changed;
      ev_next[b] = stat[b].event_bit;
    end
    any_change = |changed;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && any_change) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && any_change) begin
      out_ev <= ev_next;
    end
  end

  assign result.valid              = out_valid;
  assign result.neutral_event      = out_ev[BTN_NEUTRAL];
  assign result.screen_event       = out_ev[BTN_SCREEN];
  assign result.start_event        = out_ev[BTN_START];
  assign result.launch_event       = out_ev[BTN_LAUNCH];
  assign result.left_paddle_event  = out_ev[BTN_LEFT_PADDLE];
  assign result.right_paddle_event = out_ev[BTN_RIGHT_PADDLE];

endmodule

`default_nettype wire

### sim/six_button_debounce_event_tb.sv
// ----------------------------------------------------------------------------
// six_button_debounce_event_tb: self-checking bench of the six-button debouncer
// Drives sample words with a running millisecond clock and bouncing button
// levels, predicts the event words in a local copy of the debounce state, and
// compares every event word field by field. Runs a typed directed sequence,
// then random phases across debounce and hold settings, most with random stalls.
// ----------------------------------------------------------------------------
module six_button_debounce_event_tb;
  import sbde_pkg::*;

  localparam int ITEMS_PER_PHASE = 188;
  localparam int NUM_PHASES      = 6;
  localparam int NUM_DIRECTED    = 22;
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int MAX_REPORTS     = 10;

  // Indexes outside the register file; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    time_t      now;
    logic [5:0] levels;
  } sample_word_t;

  typedef struct {
    time_t      now;
    logic [5:0] levels;
    bit         typed;
    bit         has_word;
    logic [5:0] events;
  } directed_row_t;

  logic clk;
  logic rst;

  sbde_in_if  sample_ch ();
  sbde_out_if result_ch ();
  sbde_cfg_if cfg_ch ();

  six_button_debounce_event u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Local copy of the debounce state and settings
  logic  btn_pressed    [NUM_BUTTONS];
  time_t btn_last_edge  [NUM_BUTTONS];
  time_t btn_hold_start [NUM_BUTTONS];
  ms_t   cfg_debounce;
  ms_t   cfg_hold;

  logic [5:0] expected_events[$];
  int         fail_count;
  int         stall_cycles;
  int         send_idle_pct;
  int         recv_idle_pct;

  // Random stimulus state: running clock and the level each button aims for
  time_t      stim_clock;
  logic [5:0] stim_target;

  directed_row_t directed_rows [NUM_DIRECTED];
  ms_t           phase_debounce [NUM_PHASES];
  ms_t           phase_hold     [NUM_PHASES];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance the debounce state by one sample; report the event word if any
  function automatic void predict_events(input sample_word_t w, output logic has,
                                         output logic [5:0] ev);
    int   b;
    logic was;
    logic low;
    has = 1'b0;
    ev  = '0;
    for (b = 0; b < NUM_BUTTONS; b++) begin
      was = btn_pressed[b];
      low = ~w.levels[b];
      if (low && !was) begin
        if (time_t'(w.now - btn_last_edge[b]) >= time_t'(cfg_debounce)) begin
          // zero means no low level seen yet, so restart the hold here
          if (btn_hold_start[b] == '0) btn_hold_start[b] = w.now;
          if (time_t'(w.now - btn_hold_start[b]) >= time_t'(cfg_hold)) begin
            btn_last_edge[b] = w.now;
            btn_pressed[b]   = 1'b1;
          end
        end
      end else if (!low && was) begin
        if (time_t'(w.now - btn_last_edge[b]) >= time_t'(cfg_debounce)) begin
          btn_last_edge[b] = w.now;
          btn_pressed[b]   = 1'b0;
        end
      end
      // a high level always drops the hold start
      if (!low) btn_hold_start[b] = '0;
      if (btn_pressed[b] != was) begin
        ev[b] = btn_pressed[b];
        has   = 1'b1;
      end
    end
  endfunction

  // Build one random sample: mostly held levels with bounce, some noise, some jumps
  function automatic void make_random_word(output sample_word_t w);
    int unsigned span;
    int unsigned pick;
    int          b;
    span = ((cfg_debounce > cfg_hold) ? cfg_debounce : cfg_hold) / 3 + 2;
    pick = $urandom_range(0, 99);
    if (pick < 86) begin
      stim_clock = stim_clock + $urandom_range(0, span);
      for (b = 0; b < NUM_BUTTONS; b++) begin
        if ($urandom_range(0, 7) == 0) stim_target[b] = ~stim_target[b];
        w.levels[b] = stim_target[b] ^ ($urandom_range(0, 15) == 0);
      end
    end else if (pick < 94) begin
      stim_clock = stim_clock + $urandom_range(0, span * 4);
      w.levels   = 6'($urandom());
    end else begin
      case ($urandom_range(0, 2))
        0:       stim_clock = $urandom();
        1:       stim_clock = 32'hFFFF_FFFF - $urandom_range(0, span);
        default: stim_clock = '0;
      endcase
      w.levels = stim_target;
    end
    w.now = stim_clock;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Send one sample word; a typed row supplies its own expected event word
  task automatic send_word(input sample_word_t w, input bit typed, input bit typed_has,
                           input logic [5:0] typed_events);
    logic       has;
    logic [5:0] ev;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid              <= 1'b1;
    sample_ch.now_ms             <= w.now;
    sample_ch.neutral_level      <= w.levels[BTN_NEUTRAL];
    sample_ch.screen_level       <= w.levels[BTN_SCREEN];
    sample_ch.start_level        <= w.levels[BTN_START];
    sample_ch.launch_level       <= w.levels[BTN_LAUNCH];
    sample_ch.left_paddle_level  <= w.levels[BTN_LEFT_PADDLE];
    sample_ch.right_paddle_level <= w.levels[BTN_RIGHT_PADDLE];
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predict_events(w, has, ev);
    if (typed) begin
      has = typed_has;
      ev  = typed_events;
    end
    if (has) expected_events.push_back(ev);
  endtask

  // Write one register, then drop valid so the write is taken once
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input ms_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_DEBOUNCE: cfg_debounce = value;
      REG_HOLD:     cfg_hold     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid, wait for every expected word, then let the pipe settle
  task automatic drain;
    @(negedge clk);
    sample_ch.valid <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each event word against the oldest expectation
  always @(posedge clk) begin : check_events
    logic [5:0] seen;
    logic [5:0] want;
    bit         bad;
    int         b;
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen[BTN_NEUTRAL]      = result_ch.neutral_event;
      seen[BTN_SCREEN]       = result_ch.screen_event;
      seen[BTN_START]        = result_ch.start_event;
      seen[BTN_LAUNCH]       = result_ch.launch_event;
      seen[BTN_LEFT_PADDLE]  = result_ch.left_paddle_event;
      seen[BTN_RIGHT_PADDLE] = result_ch.right_paddle_event;
      if (expected_events.size() == 0) begin
        note_failure($sformatf("unexpected event word %b", seen));
      end else begin
        want = expected_events.pop_front();
        bad  = 1'b0;
        for (b = 0; b < NUM_BUTTONS; b++) begin
          if (seen[b] !== want[b]) bad = 1'b1;
        end
        if (bad) note_failure($sformatf("event word expected %b got %b", want, seen));
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    sample_word_t w;
    int           b;
    int           k;
    int           p;
    rst                          = 1'b1;
    sample_ch.valid              = 1'b0;
    sample_ch.now_ms             = '0;
    sample_ch.neutral_level      = 1'b1;
    sample_ch.screen_level       = 1'b1;
    sample_ch.start_level        = 1'b1;
    sample_ch.launch_level       = 1'b1;
    sample_ch.left_paddle_level  = 1'b1;
    sample_ch.right_paddle_level = 1'b1;
    result_ch.ready              = 1'b0;
    cfg_ch.valid                 = 1'b0;
    cfg_ch.index                 = REG_DEBOUNCE;
    cfg_ch.data                  = '0;
    fail_count                   = 0;
    stall_cycles                 = 0;
    cfg_debounce                 = DEBOUNCE_RESET;
    cfg_hold                     = HOLD_RESET;
    stim_clock                   = '0;
    stim_target                  = '1;
    for (b = 0; b < NUM_BUTTONS; b++) begin
      btn_pressed[b]    = 1'b0;
      btn_last_edge[b]  = '0;
      btn_hold_start[b] = '0;
    end

    // Directed sequence at reset settings; levels are indexed by button position
    directed_rows = '{
      // idle high, then low too early after reset
      '{32'd0,          6'b111111, 1'b1, 1'b0, 6'b000000},
      '{32'd0,          6'b000000, 1'b1, 1'b0, 6'b000000},
      '{32'd60,         6'b000000, 1'b1, 1'b0, 6'b000000},
      // all six pressed once the hold is met
      '{32'd110,        6'b111111 ^ 6'b111111, 1'b1, 1'b1, 6'b111111},
      // release too soon, then release accepted and reported as zeros
      '{32'd120,        6'b111111, 1'b1, 1'b0, 6'b000000},
      '{32'd160,        6'b111111, 1'b1, 1'b1, 6'b000000},
      // hold spans the wrap of the millisecond counter
      '{32'hFFFF_FFF0,  6'b111110, 1'b1, 1'b0, 6'b000000},
      '{32'd34,         6'b111110, 1'b1, 1'b1, 6'b000001},
      '{32'd100,        6'b111111, 1'b1, 1'b1, 6'b000000},
      // low first seen at time zero does not count as a started hold
      '{32'd0,          6'b111110, 1'b1, 1'b0, 6'b000000},
      '{32'd30,         6'b111110, 1'b1, 1'b0, 6'b000000},
      '{32'd50,         6'b111110, 1'b1, 1'b0, 6'b000000},
      '{32'd80,         6'b111110, 1'b1, 1'b1, 6'b000001},
      // a short high restarts the hold without any release
      '{32'd1000,       6'b111100, 1'b1, 1'b0, 6'b000000},
      '{32'd1040,       6'b111110, 1'b1, 1'b0, 6'b000000},
      '{32'd1041,       6'b111100, 1'b1, 1'b0, 6'b000000},
      '{32'd1060,       6'b111100, 1'b1, 1'b0, 6'b000000},
      '{32'd1091,       6'b111100, 1'b1, 1'b1, 6'b000010},
      // release and press on the same sample
      '{32'd1200,       6'b011101, 1'b1, 1'b1, 6'b000000},
      '{32'd1250,       6'b011110, 1'b1, 1'b1, 6'b100000},
      '{32'hFFFF_FFFF,  6'b101010, 1'b0, 1'b0, 6'b000000},
      '{32'h8000_0000,  6'b010101, 1'b0, 1'b0, 6'b000000}
    };

    phase_debounce = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0};
    phase_hold     = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0};
    phase_debounce[4] = ms_t'($urandom_range(0, 200));
    phase_hold[4]     = ms_t'($urandom_range(0, 200));
    phase_debounce[5] = ms_t'($urandom_range(0, 65535));
    phase_hold[5]     = ms_t'($urandom_range(0, 65535));

    send_idle_pct = 34;
    recv_idle_pct = 81;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < NUM_DIRECTED; k++) begin
      w.now    = directed_rows[k].now;
      w.levels = directed_rows[k].levels;
      send_word(w, directed_rows[k].typed, directed_rows[k].has_word,
                directed_rows[k].events);
    end
    drain();
    stim_clock = 32'd2000;

    // Random phases: receiver-heavy stalls, then sender-heavy, then none
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 34;
        recv_idle_pct = 81;
      end else if (p < 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, ms_t'($urandom()));
      write_reg(REG_DEBOUNCE, phase_debounce[p]);
      write_reg(REG_HOLD, phase_hold[p]);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        make_random_word(w);
        send_word(w, 1'b0, 1'b0, 6'b000000);
      end
      drain();
    end

    if (fail_count == 0 && expected_events.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/sbde_pkg.sv
sv/sbde_in_if.sv
sv/sbde_out_if.sv
sv/sbde_cfg_if.sv
sv/sbde_button.sv
sv/six_button_debounce_event.sv
sim/six_button_debounce_event_tb.sv
